@@ rtl/core/client_latency_table_with_max_top_macros.svh @@
// assertion macros for the client latency table checker
// expects clk, rst_n, out_valid and out_stall in the scope of use
`ifndef CLIENT_LATENCY_TABLE_WITH_MAX_TOP_MACROS_SVH
`define CLIENT_LATENCY_TABLE_WITH_MAX_TOP_MACROS_SVH

// generic clocked assertion, off while in reset
`define CLWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled result word must keep the given signal
`define CLWM_ASSERT_HOLD(lbl, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    out_valid && out_stall |=> $stable(sig)) else $error(msg);

`endif

@@ rtl/core/clwm_pkg.sv @@
// shared constants and types for the client latency table
// no dependencies
`timescale 1ns / 1ps

package clwm_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int KEY_PORT_WIDTH  = 16;
  localparam int CMD_WIDTH       = 2;
  localparam int STATUS_WIDTH    = 2;
  localparam int LAT_WIDTH       = 32;
  localparam int GROUP_SIZE      = 4;

  localparam logic [CMD_WIDTH-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_DEL = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_GET = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [LAT_WIDTH-1:0]    latency;
  } clwm_resp_t;

endpackage

@@ rtl/core/clwm_table.sv @@
// key table: parallel key match, lowest free slot pick, add/delete/get
// depends on clwm_pkg
`timescale 1ns / 1ps

module clwm_table #(
  parameter int DEPTH = clwm_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_W = clwm_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             exec_fire,
  input  logic [clwm_pkg::CMD_WIDTH-1:0]   cmd,
  input  logic [KEY_W-1:0]                 key,
  input  logic [clwm_pkg::LAT_WIDTH-1:0]   lat,
  output clwm_pkg::clwm_resp_t             resp,
  output logic [DEPTH-1:0]                 ent_valid,
  output logic [clwm_pkg::LAT_WIDTH-1:0]   ent_lat [DEPTH]
);
  import clwm_pkg::*;

  logic [DEPTH-1:0]     valid_r;
  logic [DEPTH-1:0]     valid_nxt;
  logic [KEY_W-1:0]     key_r [DEPTH];
  logic [LAT_WIDTH-1:0] lat_r [DEPTH];
  logic [DEPTH-1:0]     hit_oh;
  logic [DEPTH-1:0]     free_oh;
  logic [DEPTH-1:0]     wr_oh;
  logic                 any_hit;
  logic                 any_free;
  logic [LAT_WIDTH-1:0] hit_lat;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_oh[i] = valid_r[i] && (key_r[i] == key);
    end
  end

  // lowest clear bit of valid_r, isolated by the add carry
  assign free_oh  = ~valid_r & DEPTH'(valid_r + DEPTH'(1));
  assign any_hit  = |hit_oh;
  assign any_free = |free_oh;

  // keys are unique, so at most one hit
  always_comb begin
    hit_lat = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_lat = hit_lat | (lat_r[i] & {LAT_WIDTH{hit_oh[i]}});
    end
  end

  always_comb begin
    wr_oh        = '0;
    valid_nxt    = valid_r;
    resp.status  = ST_OK;
    resp.latency = '0;
    unique case (cmd)
      CMD_ADD: begin
        wr_oh     = any_hit ? hit_oh : free_oh;
        valid_nxt = valid_r | wr_oh;
        if (!any_hit && !any_free) begin
          resp.status = ST_FULL;
        end
      end
      CMD_DEL: begin
        valid_nxt = valid_r & ~hit_oh;
        if (!any_hit) begin
          resp.status = ST_NOT_FOUND;
        end
      end
      CMD_GET: begin
        resp.latency = hit_lat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (exec_fire) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (exec_fire && wr_oh[i]) begin
        key_r[i] <= key;
        lat_r[i] <= lat;
      end
    end
  end

  assign ent_valid = valid_r;
  assign ent_lat   = lat_r;

endmodule

@@ rtl/core/clwm_max_tree.sv @@
// two-level registered maximum over the valid table latencies
// depends on clwm_pkg
`timescale 1ns / 1ps

module clwm_max_tree #(
  parameter int DEPTH = clwm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic [DEPTH-1:0]                 ent_valid,
  input  logic [clwm_pkg::LAT_WIDTH-1:0]   ent_lat [DEPTH],
  input  logic                             grp_load,
  input  logic                             max_load,
  output logic [clwm_pkg::LAT_WIDTH-1:0]   max_out
);
  import clwm_pkg::*;

  localparam int NGRP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NPAD = 1 << $clog2(NGRP);

  logic [LAT_WIDTH-1:0] grp_nxt [NGRP];
  logic [LAT_WIDTH-1:0] grp_r   [NGRP];
  logic [LAT_WIDTH-1:0] red     [NPAD];
  logic [LAT_WIDTH-1:0] max_nxt;
  logic [LAT_WIDTH-1:0] max_r;

  // first level: max of each small group, empty slots count as zero
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < DEPTH) begin
          if (ent_valid[g * GROUP_SIZE + k] &&
              ent_lat[g * GROUP_SIZE + k] > grp_nxt[g]) begin
            grp_nxt[g] = ent_lat[g * GROUP_SIZE + k];
          end
        end
      end
    end
  end

  // second level: balanced pairwise reduction of the group maxima
  always_comb begin
    for (int j = 0; j < NPAD; j++) begin
      red[j] = '0;
      if (j < NGRP) begin
        red[j] = grp_r[j];
      end
    end
    for (int s = 1; s < NPAD; s = s * 2) begin
      for (int j = 0; j + s < NPAD; j = j + 2 * s) begin
        if (red[j + s] > red[j]) begin
          red[j] = red[j + s];
        end
      end
    end
    max_nxt = red[0];
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= grp_nxt;
    end
    if (max_load) begin
      max_r <= max_nxt;
    end
  end

  assign max_out = max_r;

endmodule

@@ rtl/core/client_latency_table_with_max_top.sv @@
// Client latency table with running maximum.
// Input channel (in_valid / in_stall) takes one command word: add or update,
// delete, or get, with a client key and a latency. Result channel
// (out_valid / out_stall) returns one word per command: status, the latency
// read by a get (0 otherwise), and the largest latency held after the command.
// Throughput is one command per cycle while in_stall is low. The command
// executes against the table from its input register (ex) into the rd stage,
// the mx stage registers the table's group maxima, and the out stage reduces
// those into the output register.
// When out_stall is high the four stages close up their bubbles and then
// hold; in_stall rises only once every stage holds a word. The table is only
// written when its command moves on, so the maximum always matches its word.
// Reset (rst_n low, synchronous) empties the table at once and drops every
// word in flight. The table keeps TABLE_DEPTH clients; an add of a new client
// to a full table reports full and leaves the table unchanged.
// depends on clwm_pkg, clwm_table, clwm_max_tree
`timescale 1ns / 1ps

module client_latency_table_with_max_top #(
  parameter int TABLE_DEPTH = clwm_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = clwm_pkg::KEY_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [clwm_pkg::CMD_WIDTH-1:0]      in_cmd,
  input  logic [clwm_pkg::KEY_PORT_WIDTH-1:0] in_client_key,
  input  logic [clwm_pkg::LAT_WIDTH-1:0]      in_latency_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clwm_pkg::STATUS_WIDTH-1:0]   out_status,
  output logic [clwm_pkg::LAT_WIDTH-1:0]      out_latency_out,
  output logic [clwm_pkg::LAT_WIDTH-1:0]      out_max_latency
);
  import clwm_pkg::*;

  localparam int KEY_W = (KEY_WIDTH < KEY_PORT_WIDTH) ? KEY_WIDTH : KEY_PORT_WIDTH;

  logic                 ex_valid_r, ex_valid_nxt;
  logic [CMD_WIDTH-1:0] ex_cmd_r;
  logic [KEY_W-1:0]     ex_key_r;
  logic [LAT_WIDTH-1:0] ex_lat_r;
  logic                 rd_valid_r, rd_valid_nxt;
  clwm_resp_t           rd_resp_r;
  logic                 mx_valid_r, mx_valid_nxt;
  clwm_resp_t           mx_resp_r;
  logic                 out_valid_r, out_valid_nxt;
  clwm_resp_t           out_resp_r;

  logic                 ex_en, rd_en, mx_en, out_en;
  logic                 ex_fire;
  clwm_resp_t           ex_resp;
  logic [TABLE_DEPTH-1:0] ent_valid;
  logic [LAT_WIDTH-1:0] ent_lat [TABLE_DEPTH];

  // a stage may load when empty or when its word moves on
  assign out_en  = !out_valid_r || !out_stall;
  assign mx_en   = !mx_valid_r || out_en;
  assign rd_en   = !rd_valid_r || mx_en;
  assign ex_en   = !ex_valid_r || rd_en;
  assign ex_fire = ex_valid_r && rd_en;

  assign in_stall = !ex_en;

  always_comb begin
    ex_valid_nxt  = ex_en  ? in_valid    : ex_valid_r;
    rd_valid_nxt  = rd_en  ? ex_valid_r  : rd_valid_r;
    mx_valid_nxt  = mx_en  ? rd_valid_r  : mx_valid_r;
    out_valid_nxt = out_en ? mx_valid_r  : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      rd_valid_r  <= 1'b0;
      mx_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
      mx_valid_r  <= mx_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_en && in_valid) begin
      ex_cmd_r <= in_cmd;
      ex_key_r <= in_client_key[KEY_W-1:0];
      ex_lat_r <= in_latency_in;
    end
    if (ex_fire) begin
      rd_resp_r <= ex_resp;
    end
    if (rd_valid_r && mx_en) begin
      mx_resp_r <= rd_resp_r;
    end
    if (mx_valid_r && out_en) begin
      out_resp_r <= mx_resp_r;
    end
  end

  clwm_table #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KEY_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec_fire (ex_fire),
    .cmd       (ex_cmd_r),
    .key       (ex_key_r),
    .lat       (ex_lat_r),
    .resp      (ex_resp),
    .ent_valid (ent_valid),
    .ent_lat   (ent_lat)
  );

  // group maxima are taken while the table shows exactly this word's effect
  clwm_max_tree #(
    .DEPTH (TABLE_DEPTH)
  ) u_max_tree (
    .clk       (clk),
    .ent_valid (ent_valid),
    .ent_lat   (ent_lat),
    .grp_load  (rd_valid_r && mx_en),
    .max_load  (mx_valid_r && out_en),
    .max_out   (out_max_latency)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_resp_r.status;
  assign out_latency_out = out_resp_r.latency;

endmodule

@@ rtl/core/clwm_checker.sv @@
// port-level checks for the client latency table, bound to the top level
// depends on clwm_pkg and client_latency_table_with_max_top_macros.svh
`timescale 1ns / 1ps
`include "client_latency_table_with_max_top_macros.svh"

module clwm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [clwm_pkg::STATUS_WIDTH-1:0]   out_status,
  input logic [clwm_pkg::LAT_WIDTH-1:0]      out_latency_out,
  input logic [clwm_pkg::LAT_WIDTH-1:0]      out_max_latency
);
  import clwm_pkg::*;

  `CLWM_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "result word dropped while stalled")
  `CLWM_ASSERT_HOLD(a_out_max_hold, out_max_latency, "stalled max latency changed")
  // a get only returns a latency still held, so it cannot exceed the maximum
  `CLWM_ASSERT(a_lat_le_max, out_valid |-> out_latency_out <= out_max_latency, "latency above table max")
  // error results never carry a latency
  `CLWM_ASSERT(a_err_no_lat, out_valid && out_status != ST_OK |-> out_latency_out == '0, "latency on error status")

endmodule

bind client_latency_table_with_max_top clwm_checker u_clwm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_latency_out (out_latency_out),
  .out_max_latency (out_max_latency)
);

@@ tb/tb_client_latency_table_with_max_top.sv @@
// self-checking bench for the client latency table: a clocked driver and monitor with random
// idling on both channels and a table model that predicts every result word
// depends on clwm_pkg and client_latency_table_with_max_top
`timescale 1ns / 1ps

module tb_client_latency_table_with_max_top;
  import clwm_pkg::*;

  localparam int SLOTS = TABLE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 850;
  localparam int POOL_SIZE = 24;
  localparam int CALM_TAIL = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 40;
  localparam logic [CMD_WIDTH-1:0] CMD_NONE = 2'd3;
  localparam logic [KEY_PORT_WIDTH-1:0] KEY_MASK =
    {KEY_PORT_WIDTH{1'b1}} >> (KEY_PORT_WIDTH - KEY_WIDTH_DEF);

  typedef struct {
    logic [CMD_WIDTH-1:0]      cmd;
    logic [KEY_PORT_WIDTH-1:0] key;
    logic [LAT_WIDTH-1:0]      lat;
    bit                        drain;
  } command_word_t;

  typedef struct {
    logic [STATUS_WIDTH-1:0] status;
    logic [LAT_WIDTH-1:0]    latency_out;
    logic [LAT_WIDTH-1:0]    max_latency;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_WIDTH-1:0] in_cmd = CMD_GET;
  logic [KEY_PORT_WIDTH-1:0] in_client_key = '0;
  logic [LAT_WIDTH-1:0] in_latency_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_WIDTH-1:0] out_status;
  logic [LAT_WIDTH-1:0] out_latency_out;
  logic [LAT_WIDTH-1:0] out_max_latency;

  // model of the table contents
  bit slot_used[SLOTS];
  logic [KEY_PORT_WIDTH-1:0] slot_key[SLOTS];
  logic [LAT_WIDTH-1:0] slot_lat[SLOTS];

  command_word_t pending[$];
  table_reply_t replies_due[$];
  table_reply_t head_reply;
  logic [KEY_PORT_WIDTH-1:0] key_pool[POOL_SIZE];

  int words_total = 0;
  int words_sent = 0;
  int words_seen = 0;
  int mismatch_count = 0;
  int cycles = 0;
  int gap_left = 0;
  int idle_pct = 0;
  int idle_mode_left = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int stall_mode_left = 0;

  client_latency_table_with_max_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_client_key  (in_client_key),
    .in_latency_in  (in_latency_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_latency_out(out_latency_out),
    .out_max_latency(out_max_latency)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic table_reply_t apply_command(logic [CMD_WIDTH-1:0] cmd,
                                                 logic [KEY_PORT_WIDTH-1:0] key_in,
                                                 logic [LAT_WIDTH-1:0] lat);
    table_reply_t r;
    logic [KEY_PORT_WIDTH-1:0] key;
    int hit;
    int free_slot;
    key = key_in & KEY_MASK;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    r.status = ST_OK;
    r.latency_out = '0;
    case (cmd)
      CMD_ADD: begin
        if (hit >= 0) begin
          slot_lat[hit] = lat;
        end else if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot] = key;
          slot_lat[free_slot] = lat;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_DEL: begin
        if (hit >= 0) slot_used[hit] = 1'b0;
        else r.status = ST_NOT_FOUND;
      end
      CMD_GET: begin
        if (hit >= 0) r.latency_out = slot_lat[hit];
      end
      default: ;
    endcase
    r.max_latency = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_lat[i] > r.max_latency) r.max_latency = slot_lat[i];
    end
    return r;
  endfunction

  function automatic int burst_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4;
      2: return 15;
      default: return 35;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [LAT_WIDTH-1:0] got,
                                 logic [LAT_WIDTH-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at result word %0d: %s got 0x%0h expected 0x%0h",
               words_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_cmd(logic [CMD_WIDTH-1:0] cmd, logic [KEY_PORT_WIDTH-1:0] key,
                           logic [LAT_WIDTH-1:0] lat, bit drain);
    command_word_t w;
    w.cmd = cmd;
    w.key = key;
    w.lat = lat;
    w.drain = drain;
    pending = {pending, w};
  endtask

  // driver: a word stays on the port until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due = {replies_due, apply_command(in_cmd, in_client_key, in_latency_in)};
        words_sent++;
        if (pending.size() >= CALM_TAIL && $urandom_range(0, 99) < idle_pct)
          gap_left = $urandom_range(1, 13);
      end
      if (idle_mode_left == 0) begin
        idle_pct = burst_odds();
        idle_mode_left = $urandom_range(30, 120);
      end else begin
        idle_mode_left--;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending.size() > 0 && !(pending[0].drain && replies_due.size() > 0)) begin
          in_valid <= 1'b1;
          in_cmd <= pending[0].cmd;
          in_client_key <= pending[0].key;
          in_latency_in <= pending[0].lat;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken result word and drives the stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("word with nothing pending, status", LAT_WIDTH'(out_status), '0);
        end else begin
          head_reply = replies_due.pop_front();
          if (out_status !== head_reply.status)
            report_mismatch("status", LAT_WIDTH'(out_status), LAT_WIDTH'(head_reply.status));
          if (out_latency_out !== head_reply.latency_out)
            report_mismatch("latency_out", out_latency_out, head_reply.latency_out);
          if (out_max_latency !== head_reply.max_latency)
            report_mismatch("max_latency", out_max_latency, head_reply.max_latency);
        end
        words_seen++;
      end
      if (stall_mode_left == 0) begin
        stall_pct = burst_odds();
        stall_mode_left = $urandom_range(30, 120);
      end else begin
        stall_mode_left--;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (pending.size() >= CALM_TAIL && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int phase_left;
    bit add_heavy;
    int pick;
    logic [CMD_WIDTH-1:0] cmd;
    logic [KEY_PORT_WIDTH-1:0] key;
    logic [LAT_WIDTH-1:0] lat;

    // directed: empty table, key and latency extremes, update, full table
    queue_cmd(CMD_GET, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(CMD_DEL, 16'hFFFF, '0, 1'b0);
    queue_cmd(CMD_NONE, 16'hA5A5, 32'h1234_5678, 1'b0);
    queue_cmd(CMD_ADD, 16'h0000, 32'h0000_0000, 1'b0);
    queue_cmd(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(CMD_GET, 16'hFFFF, '0, 1'b0);
    queue_cmd(CMD_ADD, 16'hFFFF, 32'h0000_0007, 1'b0);
    queue_cmd(CMD_GET, 16'h0000, '0, 1'b0);
    for (int i = 1; i <= SLOTS - 2; i++) queue_cmd(CMD_ADD, 16'(i << 4), $urandom, 1'b0);
    queue_cmd(CMD_ADD, 16'h5AA5, 32'h8000_0000, 1'b0);
    queue_cmd(CMD_ADD, 16'h0000, 32'hFFFF_FFFE, 1'b0);
    queue_cmd(CMD_NONE, 16'h0000, '0, 1'b0);
    queue_cmd(CMD_DEL, 16'h0000, '0, 1'b0);
    queue_cmd(CMD_DEL, 16'h0000, '0, 1'b0);
    queue_cmd(CMD_GET, 16'h0000, '0, 1'b0);

    // small key pool so the table fills, empties and hits often
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);

    phase_left = 0;
    add_heavy = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        add_heavy = !add_heavy;
        phase_left = $urandom_range(30, 80);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick >= 96) cmd = CMD_NONE;
      else if (pick < (add_heavy ? 55 : 20)) cmd = CMD_ADD;
      else if (pick < (add_heavy ? 75 : 60)) cmd = CMD_DEL;
      else cmd = CMD_GET;
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : 16'($urandom);
      case ($urandom_range(0, 3))
        0, 1: lat = $urandom;
        2: lat = $urandom_range(0, 255);
        default: begin
          case ($urandom_range(0, 2))
            0: lat = 32'h0000_0000;
            1: lat = 32'hFFFF_FFFF;
            default: lat = 32'h8000_0000 | $urandom;
          endcase
        end
      endcase
      // the sender waits for every result before these words
      queue_cmd(cmd, key, lat, (n % 200) == 0);
    end
    words_total = pending.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent < words_total || replies_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (replies_due.size() > 0)
      report_mismatch("results never arrived, count", replies_due.size(), 0);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
